[design/ffpa_pkg.sv]
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared widths, reset values and ring control type for the first-fit page
// run allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

   localparam int PAGE_COUNT_DEF = 1024;
   localparam int OWNER_BITS_DEF = 8;

   localparam int LEN_W      = 11;   // run_length and pages_in_use
   localparam int OWNER_IN_W = 8;    // owner_id port
   localparam int START_W    = 10;   // start_index port
   localparam int TOTAL_W    = 11;   // reserved page count
   localparam int SUM_W      = TOTAL_W + 1;

   localparam logic [LEN_W-1:0]   PAGES_RESET = 11'd1024;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 11'd2047;

   // Broadcast to every cell of the ring.
   typedef struct packed {
      logic shift;    // advance the ring by one cell
      logic clear;    // drop all tentative marks
      logic commit;   // turn tentative marks into reserved pages
   } ring_ctl_type;

endpackage

[design/ffpa_cell.sv]
// ----------------------------------------------------------------------------
// ffpa_cell
// One page slot of the rotating ring: reserved bit, tentative mark, owner.
// ----------------------------------------------------------------------------
module ffpa_cell #(
   parameter int OWNER_BITS = ffpa_pkg::OWNER_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ffpa_pkg::ring_ctl_type  ctl,
   input  logic [OWNER_BITS-1:0]   commit_owner,
   input  logic                    prev_reserved,
   input  logic                    prev_mark,
   input  logic [OWNER_BITS-1:0]   prev_owner,
   output logic                    reserved,
   output logic                    mark,
   output logic [OWNER_BITS-1:0]   owner
);

   logic                  reserved_ff, reserved_in;
   logic                  mark_ff, mark_in;
   logic [OWNER_BITS-1:0] owner_ff, owner_in;
   logic                  take;

   assign take = ctl.commit & prev_mark;

   always_comb begin
      reserved_in = prev_reserved | take;
      mark_in     = prev_mark & ~(ctl.clear | ctl.commit);
      owner_in    = take ? commit_owner : prev_owner;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= 1'b0;
         mark_ff     <= 1'b0;
         owner_ff    <= '0;
      end else if (ctl.shift) begin
         reserved_ff <= reserved_in;
         mark_ff     <= mark_in;
         owner_ff    <= owner_in;
      end
   end

   assign reserved = reserved_ff;
   assign mark     = mark_ff;
   assign owner    = owner_ff;

endmodule

[design/ffpa_head.sv]
// ----------------------------------------------------------------------------
// ffpa_head
// Scan head in the ring link: counts the free run, records its start and
// drives the ring broadcast.
// ----------------------------------------------------------------------------
module ffpa_head #(
   parameter  int PAGE_COUNT = ffpa_pkg::PAGE_COUNT_DEF,
   localparam int IDX_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1,
   localparam int CNT_W      = $clog2(PAGE_COUNT + 1),
   localparam int CMP_W      = (CNT_W > ffpa_pkg::LEN_W) ? CNT_W : ffpa_pkg::LEN_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          launch,
   input  logic                          active,
   input  logic [ffpa_pkg::LEN_W-1:0]    run_length,
   input  logic [CMP_W-1:0]              pages,
   input  logic                          page_reserved,
   output logic                          mark,
   output ffpa_pkg::ring_ctl_type        ctl,
   output logic                          last,
   output logic                          hit,
   output logic [IDX_W-1:0]              start
);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] run_ff, run_in, run_next;
   logic [IDX_W-1:0] start_ff, start_in;
   logic             searching_ff, searching_in;
   logic             hit_ff, hit_in;
   logic             probe, free, is_hit;

   always_comb begin
      free     = ~page_reserved;
      probe    = active & searching_ff & (CMP_W'(idx_ff) < pages);
      run_next = CNT_W'(run_ff + 1'b1);
      is_hit   = probe & free & (CMP_W'(run_next) == CMP_W'(run_length));
      last     = (idx_ff == IDX_W'(PAGE_COUNT - 1));

      mark       = probe & free;
      ctl.shift  = active;
      ctl.commit = is_hit;
      ctl.clear  = (probe & page_reserved) | is_hit | (active & last);

      idx_in       = idx_ff;
      run_in       = run_ff;
      start_in     = start_ff;
      searching_in = searching_ff;
      hit_in       = hit_ff;
      if (launch) begin
         idx_in       = '0;
         run_in       = '0;
         searching_in = 1'b1;
         hit_in       = 1'b0;
      end else if (active) begin
         idx_in = IDX_W'(idx_ff + 1'b1);
         if (probe) begin
            if (free) begin
               run_in = run_next;
               if (run_ff == '0) begin
                  start_in = idx_ff;
               end
               if (is_hit) begin
                  searching_in = 1'b0;
                  hit_in       = 1'b1;
               end
            end else begin
               run_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         run_ff       <= '0;
         searching_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         run_ff       <= run_in;
         searching_ff <= searching_in;
         hit_ff       <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
   end

   assign hit   = hit_ff;
   assign start = start_ff;

endmodule

[design/first_fit_page_run_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_page_run_allocator
// First-fit allocator of contiguous page runs over a ring of page cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_* beat: run_length and owner_id. rsp_* beat: found and start_index.
//   csr_wr_en/csr_wr_data write pages_in_use (size of the managed region);
//   write it only while no request is outstanding.
//   Every page lives in a cell of a ring. For a request the ring rotates
//   once past a scan head that looks at one page per cycle in ascending
//   order. Free pages of the current run get a tentative mark; a reserved
//   page drops all marks, and reaching the requested length commits them
//   as reserved under the owner.
//   A scanned request passes through SCAN while the ring rotates, then DONE,
//   then rsp_valid rises from the output register; a request that fails at
//   once (zero length, region full) skips SCAN. One request is in flight at a
//   time; the next is taken in DONE as the result moves into the output
//   register. Quick failures can follow every cycle while rsp_ready is high.
//   req_ready is low during a scan and while a finished result cannot move
//   into the output register. A stalled rsp_ready holds the result.
//   Reset frees every page, clears the owners and the count and sets
//   pages_in_use to 1024.
// ----------------------------------------------------------------------------
module first_fit_page_run_allocator #(
   parameter int PAGE_COUNT = ffpa_pkg::PAGE_COUNT_DEF,
   parameter int OWNER_BITS = ffpa_pkg::OWNER_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ffpa_pkg::LEN_W-1:0]        req_run_length,
   input  logic [ffpa_pkg::OWNER_IN_W-1:0]   req_owner_id,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_found,
   output logic [ffpa_pkg::START_W-1:0]      rsp_start_index,
   input  logic                              csr_wr_en,
   input  logic [ffpa_pkg::LEN_W-1:0]        csr_wr_data
);

   localparam int IDX_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int CNT_W = $clog2(PAGE_COUNT + 1);
   localparam int CMP_W = (CNT_W > ffpa_pkg::LEN_W) ? CNT_W : ffpa_pkg::LEN_W;
   localparam int SI_W  = ffpa_pkg::START_W;
   localparam int SUM_W = ffpa_pkg::SUM_W;
   localparam int TOT_W = ffpa_pkg::TOTAL_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type state_ff;

   // Configuration and request holding registers.
   logic [ffpa_pkg::LEN_W-1:0] pages_ff;
   logic [ffpa_pkg::LEN_W-1:0] len_ff;
   logic [OWNER_BITS-1:0]      owner_ff;
   logic [TOT_W-1:0]           total_ff, total_in;
   logic                       quick_fail_ff;

   logic                       rsp_valid_ff;
   logic                       rsp_found_ff;
   logic [SI_W-1:0]            rsp_start_ff;

   logic [CMP_W-1:0]           pages_cmp, n_eff;
   logic [SUM_W-1:0]           sum_w;
   logic                       req_beat, fail_now, launch, active, rsp_free;

   // Ring wiring.
   logic                       res_w  [PAGE_COUNT];
   logic                       mark_w [PAGE_COUNT];
   logic [OWNER_BITS-1:0]      own_w  [PAGE_COUNT];
   logic                       head_mark, head_last, head_hit;
   logic [IDX_W-1:0]           head_start;
   ffpa_pkg::ring_ctl_type     ctl;

   // In DONE with a stalled output the result must drain first; hold off
   // the next beat until the output register frees up.
   assign req_ready = (state_ff == ST_IDLE) | ((state_ff == ST_DONE) & rsp_free);
   assign req_beat  = req_valid & req_ready;
   assign active    = (state_ff == ST_SCAN);
   assign rsp_free  = ~rsp_valid_ff | rsp_ready;

   // Region size, capped at the ring size.
   always_comb begin
      pages_cmp = CMP_W'(pages_ff);
      n_eff     = (pages_cmp > CMP_W'(PAGE_COUNT)) ? CMP_W'(PAGE_COUNT) : pages_cmp;
      fail_now  = (req_run_length == '0) | (CMP_W'(total_ff) >= n_eff);
      launch    = req_beat & ~fail_now;
   end

   // Add the run to the count on commit, saturating.
   always_comb begin
      sum_w    = SUM_W'(total_ff) + SUM_W'(len_ff);
      total_in = (sum_w > SUM_W'(ffpa_pkg::TOTAL_MAX)) ? ffpa_pkg::TOTAL_MAX
                                                       : sum_w[TOT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pages_ff <= ffpa_pkg::PAGES_RESET;
      end else if (csr_wr_en) begin
         pages_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (ctl.commit) begin
         total_ff <= total_in;
      end
   end

   // Hold the request while the ring turns.
   always_ff @(posedge clock) begin
      if (req_beat) begin
         len_ff   <= req_run_length;
         owner_ff <= OWNER_BITS'(req_owner_id);
      end
   end

   // Sequencer: scan, or go straight to DONE on a quick failure, then hand the result to the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         quick_fail_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_found_ff  <= 1'b0;
         rsp_start_ff  <= '0;
      end else begin
         // Drop the taken beat; DONE reloads the register itself.
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_beat) begin
                  quick_fail_ff <= fail_now;
                  state_ff      <= fail_now ? ST_DONE : ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (head_last) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_found_ff <= ~quick_fail_ff & head_hit;
                  rsp_start_ff <= (~quick_fail_ff & head_hit) ? SI_W'(head_start) : '0;
                  // A new request may be taken in the same cycle.
                  if (req_beat) begin
                     quick_fail_ff <= fail_now;
                     state_ff      <= fail_now ? ST_DONE : ST_SCAN;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_start_index = rsp_start_ff;

   ffpa_head #(
      .PAGE_COUNT (PAGE_COUNT)
   ) u_head (
      .clock         (clock),
      .reset         (reset),
      .launch        (launch),
      .active        (active),
      .run_length    (len_ff),
      .pages         (n_eff),
      .page_reserved (res_w[PAGE_COUNT-1]),
      .mark          (head_mark),
      .ctl           (ctl),
      .last          (head_last),
      .hit           (head_hit),
      .start         (head_start)
   );

   // Cell 0 takes the page leaving the head; every other cell its neighbor.
   for (genvar k = 0; k < PAGE_COUNT; k++) begin : g_ring
      logic                  p_res;
      logic                  p_mark;
      logic [OWNER_BITS-1:0] p_own;
      if (k == 0) begin : g_first
         assign p_res  = res_w[PAGE_COUNT-1];
         assign p_mark = head_mark;
         assign p_own  = own_w[PAGE_COUNT-1];
      end else begin : g_rest
         assign p_res  = res_w[k-1];
         assign p_mark = mark_w[k-1];
         assign p_own  = own_w[k-1];
      end
      ffpa_cell #(
         .OWNER_BITS (OWNER_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (ctl),
         .commit_owner  (owner_ff),
         .prev_reserved (p_res),
         .prev_mark     (p_mark),
         .prev_owner    (p_own),
         .reserved      (res_w[k]),
         .mark          (mark_w[k]),
         .owner         (own_w[k])
      );
   end

   // Commit happens only during a scan.
   a_commit_in_scan: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |-> (state_ff == ST_SCAN))
      else $error("commit outside scan");

   // The reserved count never goes down.
   a_total_grows: assert property (@(posedge clock) disable iff (reset)
      ##1 (total_ff >= $past(total_ff)))
      else $error("reserved count decreased");

   // A commit leaves the hit flag set for the result.
   a_hit_after_commit: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |=> head_hit)
      else $error("hit flag missing after commit");

   // A found result never comes from a quick failure.
   a_found_scanned: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && rsp_found |-> $past(~quick_fail_ff))
      else $error("found on quick failure");

endmodule
